>>> hdl/rpn_pkg.sv
// Package for the postfix expression evaluator: sizes, token codes, status codes.
// No dependencies. Used by postfix_expression_evaluator.
package rpn_pkg;

  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned VALUE_WIDTH = 32;

  localparam int unsigned LEVEL_W  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned ADDR_W   = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W    = $clog2(VALUE_WIDTH);
  localparam int unsigned ADD_W    = VALUE_WIDTH + 2;
  localparam int unsigned TOKEN_W  = 8;
  localparam int unsigned OUT_W    = 32;
  localparam int unsigned STATUS_W = 3;

  localparam logic [TOKEN_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [TOKEN_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [TOKEN_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [TOKEN_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [TOKEN_W-1:0] CHAR_SLASH = 8'h2F;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 3'd0,
    ST_EMPTY = 3'd1,
    ST_UNDER = 3'd2,
    ST_OVER  = 3'd3,
    ST_DIVZ  = 3'd4
  } status_e;

  typedef logic [VALUE_WIDTH-1:0] value_t;

endpackage

>>> hdl/postfix_expression_evaluator.sv
// Postfix (RPN) expression evaluator: operand stack, sequencer and one shared adder.
// Depends on rpn_pkg.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+-----------------------
//   input   | in        | in_valid_i / in_ready_o    | token_i[7:0], last_i
//   result  | out       | out_valid_o / out_ready_i  | value_o[31:0], status_o[2:0]
//
// A digit is pushed directly; '+' and '-' load both operands, add and push;
// multiply and divide run shift-add and restoring-divide loops, one bit a cycle
// through the shared adder. An underflow, an overflow, a zero divisor or any
// token after an error sets or keeps the error and ends the token.
// Reset (rst_ni low) empties the stack and clears the error; no clearing pass.
// in_ready_o is high only between tokens. The result register holds a beat
// while out_ready_i is low; a last token then waits for it before finishing.
module postfix_expression_evaluator
  import rpn_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [TOKEN_W-1:0]  token_i,
  input  logic                last_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [OUT_W-1:0]    value_o,
  output logic [STATUS_W-1:0] status_o
);

  localparam int unsigned W = VALUE_WIDTH;
  localparam logic [CNT_W-1:0]   CNT_LAST   = CNT_W'(W - 1);
  localparam logic [LEVEL_W-1:0] LEVEL_FULL = LEVEL_W'(STACK_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE,   // waiting for a token
    S_LOAD,   // operands a and b arrive from the stack
    S_ADD,    // add or subtract
    S_MUL,    // shift-add multiply, one bit a cycle
    S_ABS_B,  // |b|
    S_ABS_A,  // |a|
    S_DIV,    // restoring divide, one quotient bit a cycle
    S_NEG_Q,  // sign fix of quotient
    S_PUSH,   // result onto the stack
    S_DONE    // end of token, result beat on last
  } state_e;

  state_e              state_q;
  logic [LEVEL_W-1:0]  level_q;
  status_e             err_q;
  logic [TOKEN_W-1:0]  tok_q;
  logic                last_q;
  value_t              x_q;     // b, then dividend/quotient, then result
  value_t              y_q;     // a, then divisor magnitude / multiplier
  value_t              rem_q;   // remainder or product accumulator
  value_t              top_q;   // copy of the top entry
  logic                sign_q;
  logic [CNT_W-1:0]    cnt_q;
  logic                out_valid_q;
  logic [OUT_W-1:0]    value_q;
  status_e             status_q;

  // operand stack: one write port, two registered read ports
  value_t              stack_mem [STACK_DEPTH];
  value_t              rd_a_q;
  value_t              rd_b_q;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  value_t              mem_wdata;
  logic [ADDR_W-1:0]   addr_a;
  logic [ADDR_W-1:0]   addr_b;

  logic                in_digit;
  value_t              digit_val;
  logic                is_add;
  logic                is_sub;
  logic                is_div;
  logic                out_load;

  // shared adder
  logic [W:0]          op_x;
  logic [W:0]          op_y;
  logic                cin;
  logic [ADD_W-1:0]    sum;
  logic                carry;
  value_t              sum_lo;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_digit   = (token_i >= CHAR_ZERO) && (token_i <= CHAR_NINE);
  // ASCII digits have their value in the low nibble
  assign digit_val  = W'(token_i[3:0]);
  assign is_add     = (tok_q == CHAR_PLUS);
  assign is_sub     = (tok_q == CHAR_MINUS);
  assign is_div     = (tok_q == CHAR_SLASH);
  assign out_load   = (state_q == S_DONE) && last_q && (!out_valid_q || out_ready_i);

  assign addr_a = ADDR_W'(level_q - LEVEL_W'(1));
  assign addr_b = ADDR_W'(level_q - LEVEL_W'(2));

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = level_q[ADDR_W-1:0];
    mem_wdata = digit_val;
    if (state_q == S_PUSH) begin
      mem_we    = 1'b1;
      mem_wdata = x_q;
    end else if (state_q == S_IDLE && in_valid_i && err_q == ST_OK && in_digit
                 && level_q != LEVEL_FULL) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      stack_mem[mem_waddr] <= mem_wdata;
    end
    rd_a_q <= stack_mem[addr_a];
    rd_b_q <= stack_mem[addr_b];
  end

  // operand select for the shared adder; subtraction is x + ~y + 1
  always_comb begin
    op_x = '0;
    op_y = '0;
    cin  = 1'b0;
    unique case (state_q)
      S_ADD: begin
        op_x = {1'b0, x_q};
        op_y = is_sub ? ~{1'b0, y_q} : {1'b0, y_q};
        cin  = is_sub;
      end
      S_MUL: begin
        op_x = {1'b0, rem_q[W-2:0], 1'b0};
        op_y = y_q[W-1] ? {1'b0, x_q} : '0;
      end
      S_ABS_B, S_NEG_Q: begin
        op_y = ~{1'b0, x_q};
        cin  = 1'b1;
      end
      S_ABS_A: begin
        op_y = ~{1'b0, y_q};
        cin  = 1'b1;
      end
      S_DIV: begin
        op_x = {rem_q, x_q[W-1]};
        op_y = ~{1'b0, y_q};
        cin  = 1'b1;
      end
      default: ;
    endcase
    sum = {1'b0, op_x} + {1'b0, op_y} + ADD_W'(cin);
  end

  assign carry  = sum[ADD_W-1];   // set when trial subtract does not borrow
  assign sum_lo = sum[W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      level_q     <= '0;
      err_q       <= ST_OK;
      tok_q       <= '0;
      last_q      <= 1'b0;
      x_q         <= '0;
      y_q         <= '0;
      rem_q       <= '0;
      top_q       <= '0;
      sign_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      value_q     <= '0;
      status_q    <= ST_OK;
    end else begin
      // a new result beat may replace one taken at the same edge
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            tok_q  <= token_i;
            last_q <= last_i;
            if (err_q != ST_OK) begin
              state_q <= S_DONE;
            end else if (in_digit) begin
              if (level_q == LEVEL_FULL) begin
                err_q <= ST_OVER;
              end else begin
                level_q <= level_q + LEVEL_W'(1);
                top_q   <= digit_val;
              end
              state_q <= S_DONE;
            end else if (level_q < LEVEL_W'(2)) begin
              err_q   <= ST_UNDER;
              state_q <= S_DONE;
            end else begin
              state_q <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          x_q     <= rd_b_q;
          y_q     <= rd_a_q;
          rem_q   <= '0;
          cnt_q   <= '0;
          sign_q  <= rd_b_q[W-1] ^ rd_a_q[W-1];
          level_q <= level_q - LEVEL_W'(2);
          if (is_add || is_sub) begin
            state_q <= S_ADD;
          end else if (is_div) begin
            if (rd_a_q == '0) begin
              err_q   <= ST_DIVZ;
              state_q <= S_DONE;
            end else begin
              state_q <= S_ABS_B;
            end
          end else begin
            state_q <= S_MUL;
          end
        end
        S_ADD: begin
          x_q     <= sum_lo;
          state_q <= S_PUSH;
        end
        S_MUL: begin
          rem_q <= sum_lo;
          y_q   <= {y_q[W-2:0], 1'b0};
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_q == CNT_LAST) begin
            x_q     <= sum_lo;
            state_q <= S_PUSH;
          end
        end
        S_ABS_B: begin
          if (x_q[W-1]) begin
            x_q <= sum_lo;
          end
          state_q <= S_ABS_A;
        end
        S_ABS_A: begin
          if (y_q[W-1]) begin
            y_q <= sum_lo;
          end
          state_q <= S_DIV;
        end
        S_DIV: begin
          x_q   <= {x_q[W-2:0], carry};
          rem_q <= carry ? sum_lo : {rem_q[W-2:0], x_q[W-1]};
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_q == CNT_LAST) begin
            state_q <= S_NEG_Q;
          end
        end
        S_NEG_Q: begin
          if (sign_q) begin
            x_q <= sum_lo;
          end
          state_q <= S_PUSH;
        end
        S_PUSH: begin
          level_q <= level_q + LEVEL_W'(1);
          top_q   <= x_q;
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (!last_q) begin
            state_q <= S_IDLE;
          end else if (out_load) begin
            if (err_q != ST_OK) begin
              value_q  <= '0;
              status_q <= err_q;
            end else if (level_q == '0) begin
              value_q  <= '0;
              status_q <= ST_EMPTY;
            end else begin
              value_q  <= OUT_W'($signed(top_q));
              status_q <= ST_OK;
            end
            level_q <= '0;
            err_q   <= ST_OK;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign status_o    = status_q;

  // stack never grows beyond its depth
  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= LEVEL_FULL)
    else $error("stack level beyond depth");

  // a push from the unit always has room
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PUSH) |-> (level_q < LEVEL_FULL))
    else $error("push onto full stack");

  // divider invariant
  a_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (rem_q < y_q))
    else $error("remainder not below divisor");

  // an error is held until the end of the expression
  a_err_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != ST_OK && !out_load) |=> (err_q == $past(err_q)))
    else $error("error code changed mid expression");

  // a result beat empties the stack
  a_clear_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (level_q == '0 && err_q == ST_OK && out_valid_o))
    else $error("stack not cleared after result");

  // failing status carries value zero
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |-> (value_o == '0))
    else $error("nonzero value with error status");

endmodule
